FILE: design/trb_pkg.sv
// Shared types, constants and helper functions of the TCP ACK/RST reply builder.
// Depends on nothing; trb_cfg_regs, trb_pipe and the top level refer to it by scoped names.
package trb_pkg;

	// Frame geometry and fixed header values of the reply.
	localparam logic [5:0]  FrameBytes  = 6'd54;
	localparam logic [5:0]  IpReplyLen  = 6'd40;
	localparam logic [15:0] TcpHdrLen   = 16'd20;
	localparam logic [7:0]  ProtoTcp    = 8'd6;
	localparam logic [3:0]  ReplyDoff   = 4'd5;
	localparam logic [15:0] FullWindow  = 16'hFFFF;
	localparam logic [15:0] IpVerIhl    = 16'h4500;

	// TCP flag codes of the reply.
	localparam logic [7:0] FlagAck = 8'h10;
	localparam logic [7:0] FlagRst = 8'h04;

	// Reply kinds carried in the op field.
	localparam logic OpAck = 1'b0;
	localparam logic OpRst = 1'b1;

	// Configuration register map.
	localparam int unsigned AddrW = 4;
	localparam logic [1:0] RegCapacity = 2'd0;
	localparam logic [1:0] RegTtl      = 2'd1;
	localparam logic [1:0] RegIdent    = 2'd2;
	localparam logic [1:0] RegTos      = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [15:0] CapacityRst = 16'd54;
	localparam logic [7:0]  TtlRst      = 8'd64;
	localparam logic [15:0] IdentRst    = 16'd0;
	localparam logic [7:0]  TosRst      = 8'd0;

	// Configuration values as seen by the datapath.
	typedef struct packed {
		logic [15:0] buffer_capacity;
		logic [7:0]  reply_ttl;
		logic [15:0] reply_ident;
		logic [7:0]  reply_tos;
	} cfg_t;

	// Folds a ones-complement sum of up to sixteen 16-bit words and inverts it.
	// Two end-around folds are enough for a 20-bit sum.
	function automatic logic [15:0] fold_invert(input logic [19:0] sum);
		logic [16:0] f1;
		logic [15:0] f2;
		f1 = 17'(sum[15:0]) + 17'(sum[19:16]);
		f2 = f1[15:0] + 16'(f1[16]);
		return ~f2;
	endfunction

endpackage

FILE: design/trb_seg_if.sv
// Channel that carries the parsed header fields of one received segment.
// Stands alone; used by the reply builder's input side.
interface trb_seg_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] rx_src_addr;
	logic [31:0] rx_dst_addr;
	logic [15:0] rx_src_port;
	logic [15:0] rx_dst_port;
	logic [31:0] rx_seq;
	logic [31:0] rx_ack;
	logic [15:0] ip_total_length;
	logic [3:0]  ip_header_words;
	logic [3:0]  tcp_header_words;
	logic        syn_seen;
	logic        fin_seen;

	modport source (
		output valid, op, rx_src_addr, rx_dst_addr, rx_src_port, rx_dst_port,
		output rx_seq, rx_ack, ip_total_length, ip_header_words, tcp_header_words,
		output syn_seen, fin_seen,
		input  ready
	);

	modport sink (
		input  valid, op, rx_src_addr, rx_dst_addr, rx_src_port, rx_dst_port,
		input  rx_seq, rx_ack, ip_total_length, ip_header_words, tcp_header_words,
		input  syn_seen, fin_seen,
		output ready
	);
endinterface

FILE: design/trb_reply_if.sv
// Channel that carries the header fields of one reply frame.
// Stands alone; used by the reply builder's output side.
interface trb_reply_if;
	logic        valid;
	logic        ready;
	logic [5:0]  reply_length;
	logic [31:0] reply_src_addr;
	logic [31:0] reply_dst_addr;
	logic [15:0] reply_src_port;
	logic [15:0] reply_dst_port;
	logic [31:0] reply_seq;
	logic [31:0] reply_ack;
	logic [7:0]  reply_flags;
	logic [15:0] reply_window;
	logic [5:0]  reply_ip_length;
	logic [15:0] reply_tcp_checksum;
	logic [15:0] reply_ip_checksum;

	modport source (
		output valid, reply_length, reply_src_addr, reply_dst_addr,
		output reply_src_port, reply_dst_port, reply_seq, reply_ack, reply_flags,
		output reply_window, reply_ip_length, reply_tcp_checksum, reply_ip_checksum,
		input  ready
	);

	modport sink (
		input  valid, reply_length, reply_src_addr, reply_dst_addr,
		input  reply_src_port, reply_dst_port, reply_seq, reply_ack, reply_flags,
		input  reply_window, reply_ip_length, reply_tcp_checksum, reply_ip_checksum,
		output ready
	);
endinterface

FILE: design/trb_cfg_regs.sv
// APB-style configuration registers of the reply builder.
// Depends on trb_pkg for the register map, reset values and cfg_t.
module trb_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [trb_pkg::AddrW-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output trb_pkg::cfg_t            cfg
);

	trb_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes on the access cycle of the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_capacity <= trb_pkg::CapacityRst;
			cfg_q.reply_ttl       <= trb_pkg::TtlRst;
			cfg_q.reply_ident     <= trb_pkg::IdentRst;
			cfg_q.reply_tos       <= trb_pkg::TosRst;
		end else if (wr_en) begin
			unique case (reg_idx)
				trb_pkg::RegCapacity: cfg_q.buffer_capacity <= pwdata[15:0];
				trb_pkg::RegTtl:      cfg_q.reply_ttl       <= pwdata[7:0];
				trb_pkg::RegIdent:    cfg_q.reply_ident     <= pwdata[15:0];
				trb_pkg::RegTos:      cfg_q.reply_tos       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data, zero extended.
	always_comb begin
		unique case (reg_idx)
			trb_pkg::RegCapacity: prdata = {16'd0, cfg_q.buffer_capacity};
			trb_pkg::RegTtl:      prdata = {24'd0, cfg_q.reply_ttl};
			trb_pkg::RegIdent:    prdata = {16'd0, cfg_q.reply_ident};
			trb_pkg::RegTos:      prdata = {24'd0, cfg_q.reply_tos};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

FILE: design/trb_pipe.sv
// Four-stage reply header pipeline: payload length, ack number, checksum sums
// and the output register. Depends on trb_pkg and the two channel interfaces.
module trb_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  trb_pkg::cfg_t cfg,
	trb_seg_if.sink       seg,
	trb_reply_if.source   reply
);

	// Stage enables: a stage loads when it is empty or its successor loads.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4     = !v_s4 || reply.ready;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign seg.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= seg.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: raw payload length and the first partial sums of both checksums.
	logic [31:0] pay_raw;
	logic [18:0] tsum_a;
	logic [18:0] isum_a;

	assign pay_raw = {16'd0, seg.ip_total_length}
		- {26'd0, seg.ip_header_words, 2'b00}
		- {26'd0, seg.tcp_header_words, 2'b00};

	assign tsum_a = 19'(seg.rx_dst_addr[31:16]) + 19'(seg.rx_dst_addr[15:0])
		+ 19'(seg.rx_src_addr[31:16]) + 19'(seg.rx_src_addr[15:0])
		+ 19'(trb_pkg::ProtoTcp) + 19'(trb_pkg::TcpHdrLen)
		+ 19'(seg.rx_dst_port) + 19'(seg.rx_src_port);

	assign isum_a = 19'(trb_pkg::IpVerIhl | {8'd0, cfg.reply_tos})
		+ 19'(trb_pkg::IpReplyLen) + 19'(cfg.reply_ident)
		+ 19'({cfg.reply_ttl, trb_pkg::ProtoTcp})
		+ 19'(seg.rx_dst_addr[31:16]) + 19'(seg.rx_dst_addr[15:0])
		+ 19'(seg.rx_src_addr[31:16]) + 19'(seg.rx_src_addr[15:0]);

	logic        op_s1, synfin_s1, cap_ok_s1;
	logic [31:0] src_addr_s1, dst_addr_s1, seq_s1, ack_s1, pay_s1;
	logic [15:0] src_port_s1, dst_port_s1;
	logic [18:0] tsum_s1, isum_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1       <= seg.op;
			synfin_s1   <= seg.syn_seen || seg.fin_seen;
			cap_ok_s1   <= cfg.buffer_capacity >= 16'(trb_pkg::FrameBytes);
			src_addr_s1 <= seg.rx_src_addr;
			dst_addr_s1 <= seg.rx_dst_addr;
			src_port_s1 <= seg.rx_src_port;
			dst_port_s1 <= seg.rx_dst_port;
			seq_s1      <= seg.rx_seq;
			ack_s1      <= seg.rx_ack;
			pay_s1      <= pay_raw;
			tsum_s1     <= tsum_a;
			isum_s1     <= isum_a;
		end
	end

	// Stage 2: SYN/FIN adjustment, reply ack number, flags and window.
	logic [31:0] pay_fix;
	logic [31:0] rack_c;

	assign pay_fix = (synfin_s1 && pay_s1 == 32'd0) ? 32'd1 : pay_s1;
	assign rack_c  = (op_s1 == trb_pkg::OpRst) ? 32'd0 : seq_s1 + pay_fix;

	logic        cap_ok_s2;
	logic [31:0] src_addr_s2, dst_addr_s2, ack_s2, rack_s2;
	logic [15:0] src_port_s2, dst_port_s2, win_s2;
	logic [7:0]  flags_s2;
	logic [19:0] tsum_s2;
	logic [18:0] isum_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cap_ok_s2   <= cap_ok_s1;
			src_addr_s2 <= src_addr_s1;
			dst_addr_s2 <= dst_addr_s1;
			src_port_s2 <= src_port_s1;
			dst_port_s2 <= dst_port_s1;
			ack_s2      <= ack_s1;
			rack_s2     <= rack_c;
			flags_s2    <= (op_s1 == trb_pkg::OpRst) ? trb_pkg::FlagRst : trb_pkg::FlagAck;
			win_s2      <= (op_s1 == trb_pkg::OpRst) ? 16'd0 : trb_pkg::FullWindow;
			tsum_s2     <= 20'(tsum_s1) + 20'(ack_s1[31:16]) + 20'(ack_s1[15:0]);
			isum_s2     <= isum_s1;
		end
	end

	// Stage 3: finish the TCP sum with the ack, flag and window words.
	logic        cap_ok_s3;
	logic [31:0] src_addr_s3, dst_addr_s3, ack_s3, rack_s3;
	logic [15:0] src_port_s3, dst_port_s3, win_s3;
	logic [7:0]  flags_s3;
	logic [19:0] tsum_s3;
	logic [18:0] isum_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cap_ok_s3   <= cap_ok_s2;
			src_addr_s3 <= src_addr_s2;
			dst_addr_s3 <= dst_addr_s2;
			src_port_s3 <= src_port_s2;
			dst_port_s3 <= dst_port_s2;
			ack_s3      <= ack_s2;
			rack_s3     <= rack_s2;
			flags_s3    <= flags_s2;
			win_s3      <= win_s2;
			tsum_s3     <= tsum_s2 + 20'(rack_s2[31:16]) + 20'(rack_s2[15:0])
				+ 20'({trb_pkg::ReplyDoff, 4'h0, flags_s2}) + 20'(win_s2);
			isum_s3     <= isum_s2;
		end
	end

	// Stage 4: fold the checksums; a too-small buffer zeroes the whole item.
	logic [5:0]  len_s4, iplen_s4;
	logic [31:0] src_addr_s4, dst_addr_s4, seq_s4, ack_s4;
	logic [15:0] src_port_s4, dst_port_s4, win_s4, tcsum_s4, icsum_s4;
	logic [7:0]  flags_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			if (cap_ok_s3) begin
				len_s4      <= trb_pkg::FrameBytes;
				iplen_s4    <= trb_pkg::IpReplyLen;
				src_addr_s4 <= dst_addr_s3;
				dst_addr_s4 <= src_addr_s3;
				src_port_s4 <= dst_port_s3;
				dst_port_s4 <= src_port_s3;
				seq_s4      <= ack_s3;
				ack_s4      <= rack_s3;
				flags_s4    <= flags_s3;
				win_s4      <= win_s3;
				tcsum_s4    <= trb_pkg::fold_invert(tsum_s3);
				icsum_s4    <= trb_pkg::fold_invert(20'(isum_s3));
			end else begin
				len_s4      <= 6'd0;
				iplen_s4    <= 6'd0;
				src_addr_s4 <= 32'd0;
				dst_addr_s4 <= 32'd0;
				src_port_s4 <= 16'd0;
				dst_port_s4 <= 16'd0;
				seq_s4      <= 32'd0;
				ack_s4      <= 32'd0;
				flags_s4    <= 8'd0;
				win_s4      <= 16'd0;
				tcsum_s4    <= 16'd0;
				icsum_s4    <= 16'd0;
			end
		end
	end

	assign reply.valid              = v_s4;
	assign reply.reply_length       = len_s4;
	assign reply.reply_src_addr     = src_addr_s4;
	assign reply.reply_dst_addr     = dst_addr_s4;
	assign reply.reply_src_port     = src_port_s4;
	assign reply.reply_dst_port     = dst_port_s4;
	assign reply.reply_seq          = seq_s4;
	assign reply.reply_ack          = ack_s4;
	assign reply.reply_flags        = flags_s4;
	assign reply.reply_window       = win_s4;
	assign reply.reply_ip_length    = iplen_s4;
	assign reply.reply_tcp_checksum = tcsum_s4;
	assign reply.reply_ip_checksum  = icsum_s4;

	// A stalled output must hold the item waiting behind it in stage 3.
	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !reply.ready && v_s3 |=> v_s3)
		else $error("stage 3 item lost during output stall");

	// The frame length is either a full frame or zero.
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (len_s4 == trb_pkg::FrameBytes || len_s4 == 6'd0))
		else $error("illegal reply length");

	// A built frame always carries the fixed IP length.
	a_iplen_match: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && len_s4 == trb_pkg::FrameBytes |-> iplen_s4 == trb_pkg::IpReplyLen)
		else $error("IP length does not match a built frame");

	// A reset reply carries neither an ack number nor a window.
	a_rst_fields: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && flags_s4 == trb_pkg::FlagRst |-> ack_s4 == 32'd0 && win_s4 == 16'd0)
		else $error("RST reply with nonzero ack or window");

endmodule

FILE: design/tcp_ack_rst_reply_builder_core.sv
// Top level of the TCP ACK/RST reply builder.
// Depends on trb_pkg, trb_seg_if, trb_reply_if, trb_cfg_regs and trb_pipe.

// The block takes the parsed header fields of one received IPv4/TCP segment per
// item and returns the header fields of a 54-byte ACK or RST reply, with both
// checksums filled in. It accepts one item every clock cycle while its ready
// is high. Each item passes through the four register stages of the pipeline
// (payload length, ack adder, checksum sums, fold and output register) before
// it is valid on the reply channel. When the reply channel stalls, the pipeline
// fills its empty stages first and then holds ready low. Configuration registers
// (buffer capacity at 0x0, TTL at 0x4, identification at 0x8, TOS at 0xC) are to
// be written by the user over the APB port only while no item is in flight; the
// block itself does not enforce it. A capacity under 54 turns every reply into
// an all-zero item.
module tcp_ack_rst_reply_builder_core (
	input  logic                      clk,
	input  logic                      arst_n,
	trb_seg_if.sink                   seg,
	trb_reply_if.source               reply,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [trb_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	trb_pkg::cfg_t cfg;

	// Configuration register file.
	trb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Reply header pipeline.
	trb_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.seg    (seg),
		.reply  (reply)
	);

endmodule
